// ===== rtl/core/bim_pkg.sv =====
// Shared constants for the broadcast index map.
package bim_pkg;
	localparam int MAX_DIMS_DEF    = 4;
	localparam int INDEX_WIDTH_DEF = 32;
	localparam int EXT_W           = 16;
	localparam int NUM_REG_DIMS    = 4;
	localparam int CFG_IDX_W       = 3;
	localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(1);
endpackage

// ===== rtl/core/bim_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per word.
module bim_div_cell #(
	parameter int IW = bim_pkg::INDEX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [bim_pkg::EXT_W-1:0] divisor,
	input  logic                      v_i,
	input  logic [IW-1:0]             work_i,
	input  logic [bim_pkg::EXT_W-1:0] rem_i,
	input  logic [IW-1:0]             acc_i,
	output logic                      v_q,
	output logic [IW-1:0]             work_q,
	output logic [bim_pkg::EXT_W-1:0] rem_q,
	output logic [IW-1:0]             acc_q
);
	logic [bim_pkg::EXT_W:0] r_ext;
	logic                    ge;

	assign r_ext = {rem_i, work_i[IW-1]};
	assign ge    = (r_ext >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	// shift the dividend out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= {work_i[IW-2:0], ge};
			rem_q  <= ge ? bim_pkg::EXT_W'(r_ext - {1'b0, divisor})
			             : r_ext[bim_pkg::EXT_W-1:0];
			acc_q  <= acc_i;
		end
	end
endmodule

// ===== rtl/core/bim_acc_cell.sv =====
// Accumulate cell: adds the coordinate of one dimension times its input weight when use_coord is set.
module bim_acc_cell #(
	parameter int IW = bim_pkg::INDEX_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      use_coord,
	input  logic [IW-1:0]             weight,
	input  logic                      v_i,
	input  logic [IW-1:0]             work_i,
	input  logic [bim_pkg::EXT_W-1:0] rem_i,
	input  logic [IW-1:0]             acc_i,
	output logic                      v_q,
	output logic [IW-1:0]             work_q,
	output logic [bim_pkg::EXT_W-1:0] rem_q,
	output logic [IW-1:0]             acc_q
);
	logic [IW+bim_pkg::EXT_W-1:0] prod;

	assign prod = rem_i * weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	// the remainder is the coordinate; clear it for the next dimension
	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= work_i;
			rem_q  <= '0;
			acc_q  <= use_coord ? IW'(acc_i + prod[IW-1:0]) : acc_i;
		end
	end
endmodule

// ===== rtl/core/broadcast_index_map_unit.sv =====
// Top level of the broadcast index map: config registers and the cell chain.
//
// Usage: configure out/in extents on the cfg channel (index 0..3 output
// extents, 4..7 input extents, outermost first) while the block is idle.
// Then stream flat output indices on s_* (s_tdata) and collect the source
// indices on m_* (m_tdata, m_tuser = out_of_range).
// Throughput: one word per cycle while the output is not stalled. The chain
// holds INDEX_WIDTH one-bit division cells per dimension and one accumulate
// cell per dimension, each a register stage. Input weights are registered
// products that settle through the chain of weight registers after a write.
// Reset empties the chain and sets every extent to 1.
// When m_tready is low with a word waiting, the whole chain holds and
// s_tready drops; words in flight are kept, none are lost.
// An index at or beyond the element count returns out_of_range with
// m_tdata zero.
module broadcast_index_map_unit #(
	parameter int MAX_DIMS    = bim_pkg::MAX_DIMS_DEF,
	parameter int INDEX_WIDTH = bim_pkg::INDEX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((INDEX_WIDTH+7)/8)*8-1:0] s_tdata, // out_index
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((INDEX_WIDTH+7)/8)*8-1:0] m_tdata, // in_index
	output logic                          m_tuser,  // out_of_range
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bim_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bim_pkg::EXT_W-1:0]     cfg_data
);
	localparam int IW     = INDEX_WIDTH;
	localparam int TW     = ((INDEX_WIDTH+7)/8)*8;
	localparam int CELLS  = IW + 1;
	localparam int NST    = MAX_DIMS * CELLS;
	localparam int EW     = bim_pkg::EXT_W;

	logic [EW-1:0] out_ext_q [MAX_DIMS];
	logic [EW-1:0] in_ext_q  [MAX_DIMS];
	logic [IW-1:0] weight_q  [MAX_DIMS];
	logic          zero_ext_q;

	logic          v_w    [NST+1];
	logic [IW-1:0] work_w [NST+1];
	logic [EW-1:0] rem_w  [NST+1];
	logic [IW-1:0] acc_w  [NST+1];
	logic          en;
	logic          oor;

	assign cfg_ready = 1'b1;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cfg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				out_ext_q[d] <= bim_pkg::EXT_RESET;
				in_ext_q[d]  <= bim_pkg::EXT_RESET;
			end else if (cfg_valid && d < bim_pkg::NUM_REG_DIMS) begin
				if (32'(cfg_index) == d)
					out_ext_q[d] <= cfg_data;
				if (32'(cfg_index) == d + bim_pkg::NUM_REG_DIMS)
					in_ext_q[d] <= cfg_data;
			end
		end
	end

	// input weights: product of the input extents to the right
	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_wt
		if (d == MAX_DIMS - 1) begin : g_last
			always_ff @(posedge clk) begin
				weight_q[d] <= IW'(1);
			end
		end else begin : g_mid
			logic [IW+EW-1:0] wp;
			assign wp = weight_q[d+1] * in_ext_q[d+1];
			always_ff @(posedge clk) begin
				weight_q[d] <= wp[IW-1:0];
			end
		end
	end

	always_comb begin
		oor = 1'b0;
		for (int d = 0; d < MAX_DIMS; d++)
			if (out_ext_q[d] == '0)
				oor = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_ext_q <= 1'b0;
		end else begin
			zero_ext_q <= oor;
		end
	end

	// advance the whole chain unless the output word is stalled
	assign en       = m_tready || !v_w[NST];
	assign s_tready = en;

	assign v_w[0]    = s_tvalid;
	assign work_w[0] = s_tdata[IW-1:0];
	assign rem_w[0]  = '0;
	assign acc_w[0]  = '0;

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
		for (genvar b = 0; b < IW; b++) begin : g_bit
			bim_div_cell #(.IW(IW)) u_div (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.divisor (out_ext_q[MAX_DIMS-1-k]),
				.v_i     (v_w[k*CELLS+b]),
				.work_i  (work_w[k*CELLS+b]),
				.rem_i   (rem_w[k*CELLS+b]),
				.acc_i   (acc_w[k*CELLS+b]),
				.v_q     (v_w[k*CELLS+b+1]),
				.work_q  (work_w[k*CELLS+b+1]),
				.rem_q   (rem_w[k*CELLS+b+1]),
				.acc_q   (acc_w[k*CELLS+b+1])
			);
		end
		bim_acc_cell #(.IW(IW)) u_acc (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.use_coord (in_ext_q[MAX_DIMS-1-k] > EW'(1)),
			.weight    (weight_q[MAX_DIMS-1-k]),
			.v_i       (v_w[k*CELLS+IW]),
			.work_i    (work_w[k*CELLS+IW]),
			.rem_i     (rem_w[k*CELLS+IW]),
			.acc_i     (acc_w[k*CELLS+IW]),
			.v_q       (v_w[k*CELLS+CELLS]),
			.work_q    (work_w[k*CELLS+CELLS]),
			.rem_q     (rem_w[k*CELLS+CELLS]),
			.acc_q     (acc_w[k*CELLS+CELLS])
		);
	end

	// a quotient left after all extents means the index is past the end
	assign m_tvalid = v_w[NST];
	assign m_tuser  = zero_ext_q || (work_w[NST] != '0);
	assign m_tdata  = m_tuser ? '0 : TW'(acc_w[NST]);

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out_of_range word carries a nonzero index");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (m_tready || !m_tvalid))
		else $error("input ready does not follow the output stall");
	a_zero_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && zero_ext_q |-> m_tuser)
		else $error("zero extent did not flag out_of_range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(acc_w[NST]) && $stable(work_w[NST]))
		else $error("stalled chain tail moved");
endmodule

// ===== tb/tb_broadcast_index_map_checker.sv =====
// Checker for the broadcast index map: mirrors the extents, predicts and compares results.
`timescale 1ns / 1ps
module tb_broadcast_index_map_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // out_index
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // in_index
	input  logic        m_tuser,   // out_of_range
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [bim_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bim_pkg::EXT_W-1:0]     cfg_data,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [31:0] in_index;
		logic        out_of_range;
	} source_ref_t;

	logic [63:0] out_ext [4];
	logic [63:0] in_ext [4];
	source_ref_t expected_refs [$];

	function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
	endfunction

	function automatic source_ref_t map_index(logic [31:0] flat);
		logic [63:0] stride [4];
		logic [63:0] count, rem, coord;
		logic [31:0] acc;
		source_ref_t r;
		count = 1;
		for (int i = 3; i >= 0; i--) begin
			stride[i] = count;
			count = sat_mul(count, out_ext[i]);
		end
		if (count == 0 || {32'd0, flat} >= count) begin
			r.in_index = '0;
			r.out_of_range = 1'b1;
			return r;
		end
		rem = {32'd0, flat};
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			coord = rem / stride[i];
			rem = rem % stride[i];
			acc = acc * in_ext[i][31:0];
			if (in_ext[i] > 1)
				acc = acc + coord[31:0];
		end
		r.in_index = acc;
		r.out_of_range = 1'b0;
		return r;
	endfunction

	assign pending = expected_refs.size();

	always @(posedge clk or negedge arst_n) begin
		source_ref_t e;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				out_ext[i] <= 64'd1;
				in_ext[i] <= 64'd1;
			end
			expected_refs.delete();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < bim_pkg::NUM_REG_DIMS)
					out_ext[cfg_index[1:0]] <= {48'd0, cfg_data};
				else
					in_ext[cfg_index[1:0]] <= {48'd0, cfg_data};
			end
			if (s_tvalid && s_tready)
				expected_refs.push_back(map_index(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_refs.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: in_index %h oor %b", m_tdata, m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_refs.pop_front();
					if (e.in_index !== m_tdata || e.out_of_range !== m_tuser) begin
						if (fail_count < 10)
							$display("mismatch: exp %h/%b got %h/%b",
								e.in_index, e.out_of_range, m_tdata, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_broadcast_index_map_unit.sv =====
// Testbench top for the broadcast index map: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_broadcast_index_map_unit;
	localparam int LATENCY = 4 * 33;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // out_index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // in_index
	logic        m_tuser;         // out_of_range
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [bim_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bim_pkg::EXT_W-1:0]     cfg_data = '0;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	bit          hold_off = 1'b0;
	logic [15:0] oext [4];

	broadcast_index_map_unit i_dut (.*);

	tb_broadcast_index_map_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(8, 60)) begin
				@(posedge clk);
				if (hold_off)
					m_tready <= 1'b0;
				else
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= ($urandom_range(0, 3) != 0);
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
			end
		end
	end

	task automatic write_reg(int idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx[bim_pkg::CFG_IDX_W-1:0];
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_shape(logic [15:0] o0, o1, o2, o3, i0, i1, i2, i3);
		logic [15:0] ov [4];
		logic [15:0] iv [4];
		ov = '{o0, o1, o2, o3};
		iv = '{i0, i1, i2, i3};
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		for (int d = 0; d < 4; d++) begin
			write_reg(d, ov[d]);
			write_reg(d + bim_pkg::NUM_REG_DIMS, iv[d]);
			oext[d] = ov[d];
		end
		repeat (8) @(posedge clk);
	endtask

	// send one word; s_tvalid stays high while sending back-to-back
	task automatic send_index(logic [31:0] v);
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic gap();
		s_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic logic [31:0] element_count();
		logic [63:0] c;
		c = 1;
		for (int d = 0; d < 4; d++) c = c * oext[d];
		return (c[63:32] != 0) ? 32'hFFFF_FFFF : c[31:0];
	endfunction

	task automatic random_burst(int n);
		logic [31:0] cnt;
		int burst;
		cnt = element_count();
		while (n > 0) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && n > 0; k++, n--) begin
				if ($urandom_range(0, 9) == 0 || cnt == 0)
					send_index($urandom());
				else
					send_index($urandom_range(0, cnt - 1));
			end
			if ($urandom_range(0, 3) != 0) gap();
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic random_shape();
		logic [15:0] o [4];
		logic [15:0] iv [4];
		for (int d = 0; d < 4; d++) begin
			o[d] = 16'($urandom_range(1, 9));
			case ($urandom_range(0, 5))
				0, 1: iv[d] = 16'd1;
				2: iv[d] = 16'($urandom_range(0, 12));
				default: iv[d] = o[d];
			endcase
		end
		set_shape(o[0], o[1], o[2], o[3], iv[0], iv[1], iv[2], iv[3]);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (10) @(posedge clk);
		for (int d = 0; d < 4; d++) oext[d] = 1;
		// reset shape: only index 0 in range
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'hFFFF_FFFF);
		gap();
		set_shape(3, 4, 5, 6, 1, 4, 1, 6);
		send_index(0);
		send_index(359);
		send_index(360);
		send_index(32'h8000_0000);
		send_index(123);
		gap();
		// largest extents: every 32-bit index is in range
		set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_index(32'hFFFF_FFFF);
		send_index(32'h5555_AAAA);
		send_index(32'hAAAA_5555);
		send_index(0);
		gap();
		// zero output extent: all out of range; then a zero input extent
		set_shape(2, 0, 3, 3, 2, 1, 3, 3);
		send_index(0);
		send_index(5);
		gap();
		set_shape(2, 3, 4, 5, 0, 3, 7, 5);
		send_index(119);
		send_index(77);
		send_index(26);
		send_index(120);
		gap();
		// fill the pipe while the receiver holds off
		hold_off = 1'b1;
		fork
			random_burst(200);
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		for (int ph = 0; ph < 10; ph++) begin
			random_shape();
			random_burst(60);
		end
		set_shape(1, 1, 256, 256, 1, 1, 1, 256);
		random_burst(30);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/bim_pkg.sv
rtl/core/bim_div_cell.sv
rtl/core/bim_acc_cell.sv
rtl/core/broadcast_index_map_unit.sv
tb/tb_broadcast_index_map_checker.sv
tb/tb_broadcast_index_map_unit.sv
